@@ rtl/core/ppsm_pkg.sv @@
// Shared constants for the priority preempting slot manager.
// Request codes, status codes, field widths and reset defaults.
// No dependencies.
package ppsm_pkg;

  localparam int ID_W    = 8;
  localparam int PRIO_W  = 8;
  localparam int LIMIT_W = 3;
  localparam int REQ_W   = 2;
  localparam int ST_W    = 2;

  localparam int HOLDER_DEPTH_DEF = 4;
  localparam int WAITER_DEPTH_DEF = 8;

  localparam logic [LIMIT_W-1:0] DEC_LIMIT_RST = 3'd3;
  localparam logic [LIMIT_W-1:0] ENC_LIMIT_RST = 3'd1;

  // configuration register indexes
  localparam logic CFG_DEC_LIMIT = 1'b0;
  localparam logic CFG_ENC_LIMIT = 1'b1;

  localparam logic [REQ_W-1:0] REQ_ACQUIRE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WAIT_IN = 2'd2;
  localparam logic [REQ_W-1:0] REQ_WAIT_OUT = 2'd3;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_INSUFF   = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDEF    = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

@@ rtl/core/ppsm_ram.sv @@
// Simple dual-port list storage: one write port, one registered read port.
// Used for the holder and waiter lists. No package dependency.
module ppsm_ram #(
  parameter int WIDTH = 8,
  parameter int AW    = 2
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [2**AW];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/priority_preempting_slot_manager_unit.sv @@
// Slot manager top level: sequencer, counters, config and shared comparator.
// Depends on ppsm_pkg and ppsm_ram.
//
// Usage:
//   Requests enter on start with in_req_type, in_pool_select, in_client_id and
//   in_client_priority; a request is taken at a clock edge with start high and
//   busy low. Each request gives exactly one result, shown for one cycle with
//   out_valid high. The receiver cannot stall; results must be taken as shown.
//   Steps per request kind:
//     immediate results (empty or full list, limit of zero): the result only
//     append to a holder or waiting list: an append step, then the result
//     acquire with preemption: priority scan, find and shift, append, result
//     release: find and shift, then a read and shift of the waiting list when
//       a waiter is woken
//     wait-leave: find and shift in the waiting list
//   Every list step is a read state and a compare state: the list memory has one
//   registered read port, and one 8-bit comparator is shared by all scans. busy is
//   high from the cycle after acceptance until the result cycle and stays low for
//   immediate results; the next request may start in the cycle out_valid shows.
//   cfg_we writes a slot limit; write it only while idle.
//   Synchronous reset (rst_n low) empties all lists through their counts and
//   restores the limits to 3 (decoder) and 1 (encoder); list contents are left.
module priority_preempting_slot_manager_unit #(
  parameter int HOLDER_DEPTH = ppsm_pkg::HOLDER_DEPTH_DEF,
  parameter int WAITER_DEPTH = ppsm_pkg::WAITER_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [ppsm_pkg::REQ_W-1:0]     in_req_type,
  input  logic                           in_pool_select,
  input  logic [ppsm_pkg::ID_W-1:0]      in_client_id,
  input  logic [ppsm_pkg::PRIO_W-1:0]    in_client_priority,
  output logic                           out_valid,
  output logic [ppsm_pkg::ST_W-1:0]      out_status,
  output logic                           out_evicted_valid,
  output logic [ppsm_pkg::ID_W-1:0]      out_evicted_id,
  output logic                           out_wake_valid,
  output logic [ppsm_pkg::ID_W-1:0]      out_wake_id,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [ppsm_pkg::LIMIT_W-1:0]   cfg_wdata
);

  localparam int ID_W    = ppsm_pkg::ID_W;
  localparam int PRIO_W  = ppsm_pkg::PRIO_W;
  localparam int HIDX_W  = (HOLDER_DEPTH > 1) ? $clog2(HOLDER_DEPTH) : 1;
  localparam int WIDX_W  = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
  localparam int HCNT_W  = $clog2(HOLDER_DEPTH + 1);
  localparam int WCNT_W  = $clog2(WAITER_DEPTH + 1);
  localparam int IW      = (HCNT_W > WCNT_W) ? HCNT_W : WCNT_W;
  localparam int LW      = (HCNT_W > ppsm_pkg::LIMIT_W) ? HCNT_W : ppsm_pkg::LIMIT_W;
  localparam int HE_W    = ID_W + PRIO_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_RD     = 2'd1;
  localparam logic [1:0] S_CMP    = 2'd2;
  localparam logic [1:0] S_APPEND = 2'd3;

  localparam logic [2:0] PH_PRIO   = 3'd0;
  localparam logic [2:0] PH_HFIND  = 3'd1;
  localparam logic [2:0] PH_HSHIFT = 3'd2;
  localparam logic [2:0] PH_WHEAD  = 3'd3;
  localparam logic [2:0] PH_WFIND  = 3'd4;
  localparam logic [2:0] PH_WSHIFT = 3'd5;

  logic [1:0]                    state_r, state_nxt;
  logic [2:0]                    phase_r, phase_nxt;
  logic [ppsm_pkg::REQ_W-1:0]    req_r, req_nxt;
  logic                          pool_r, pool_nxt;
  logic [ID_W-1:0]               id_r, id_nxt;
  logic [PRIO_W-1:0]             prio_r, prio_nxt;
  logic [7:0]                    op_r, op_nxt;
  logic [IW-1:0]                 idx_r, idx_nxt;
  logic [IW-1:0]                 end_r, end_nxt;
  logic                          found_r, found_nxt;
  logic                          app_wait_r, app_wait_nxt;
  logic [ppsm_pkg::ST_W-1:0]     status_r, status_nxt;
  logic                          evv_r, evv_nxt;
  logic [ID_W-1:0]               evid_r, evid_nxt;
  logic                          wkv_r, wkv_nxt;
  logic [ID_W-1:0]               wkid_r, wkid_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [HCNT_W-1:0]             hcnt_r [2];
  logic [HCNT_W-1:0]             hcnt_nxt [2];
  logic [WCNT_W-1:0]             wcnt_r [2];
  logic [WCNT_W-1:0]             wcnt_nxt [2];
  logic [ppsm_pkg::LIMIT_W-1:0]  lim_r [2];

  // list memories
  logic              h_we, w_we;
  logic [HIDX_W:0]   h_waddr, h_raddr;
  logic [WIDX_W:0]   w_waddr, w_raddr;
  logic [HE_W-1:0]   h_wdata, h_rdata;
  logic [ID_W-1:0]   w_wdata, w_rdata;
  logic [IW-1:0]     rd_idx;
  logic [ID_W-1:0]   h_rd_id;
  logic [PRIO_W-1:0] h_rd_prio;

  // shared comparator
  logic [7:0] cmp_a;
  logic       cmp_gt, cmp_eq;

  logic [HCNT_W-1:0] hcnt_i;
  logic [WCNT_W-1:0] wcnt_i;
  logic [ppsm_pkg::LIMIT_W-1:0] lim_i;
  logic [IW:0]       idx_p1, idx_p2;
  logic              is_last, is_last2;

  assign h_rd_id   = h_rdata[HE_W-1:PRIO_W];
  assign h_rd_prio = h_rdata[PRIO_W-1:0];

  assign rd_idx  = (phase_r == PH_HSHIFT || phase_r == PH_WSHIFT) ? IW'(idx_r + 1'b1) : idx_r;
  assign h_raddr = {pool_r, rd_idx[HIDX_W-1:0]};
  assign w_raddr = {pool_r, rd_idx[WIDX_W-1:0]};
  assign h_waddr = {pool_r, idx_r[HIDX_W-1:0]};
  assign w_waddr = {pool_r, idx_r[WIDX_W-1:0]};

  always_comb begin
    case (phase_r)
      PH_PRIO:   cmp_a = h_rd_prio;
      PH_HFIND:  cmp_a = h_rd_id;
      default:   cmp_a = w_rdata;
    endcase
  end

  assign cmp_gt = cmp_a > op_r;
  assign cmp_eq = cmp_a == op_r;

  assign idx_p1   = {1'b0, idx_r} + 1'b1;
  assign idx_p2   = {1'b0, idx_r} + 2'd2;
  assign is_last  = idx_p1 >= {1'b0, end_r};
  assign is_last2 = idx_p2 >= {1'b0, end_r};

  assign hcnt_i = hcnt_r[in_pool_select];
  assign wcnt_i = wcnt_r[in_pool_select];
  assign lim_i  = lim_r[in_pool_select];

  always_comb begin
    logic hsh_done;
    logic wsh_done;
    logic finish;
    hsh_done      = 1'b0;
    wsh_done      = 1'b0;
    finish        = 1'b0;
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    req_nxt       = req_r;
    pool_nxt      = pool_r;
    id_nxt        = id_r;
    prio_nxt      = prio_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    end_nxt       = end_r;
    found_nxt     = found_r;
    app_wait_nxt  = app_wait_r;
    status_nxt    = status_r;
    evv_nxt       = evv_r;
    evid_nxt      = evid_r;
    wkv_nxt       = wkv_r;
    wkid_nxt      = wkid_r;
    hcnt_nxt      = hcnt_r;
    wcnt_nxt      = wcnt_r;
    h_we          = 1'b0;
    w_we          = 1'b0;
    h_wdata       = h_rdata;
    w_wdata       = w_rdata;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt    = in_req_type;
          pool_nxt   = in_pool_select;
          id_nxt     = in_client_id;
          prio_nxt   = in_client_priority;
          status_nxt = ppsm_pkg::ST_OK;
          evv_nxt    = 1'b0;
          evid_nxt   = '0;
          wkv_nxt    = 1'b0;
          wkid_nxt   = '0;
          idx_nxt    = '0;
          found_nxt  = 1'b0;
          case (in_req_type)
            ppsm_pkg::REQ_ACQUIRE: begin
              if (hcnt_i < HCNT_W'(HOLDER_DEPTH) && LW'(hcnt_i) < LW'(lim_i)) begin
                idx_nxt                  = IW'(hcnt_i);
                app_wait_nxt             = 1'b0;
                hcnt_nxt[in_pool_select] = hcnt_i + 1'b1;
                state_nxt                = S_APPEND;
              end else if (hcnt_i == '0) begin
                status_nxt = ppsm_pkg::ST_INSUFF;
                finish     = 1'b1;
              end else begin
                phase_nxt = PH_PRIO;
                op_nxt    = in_client_priority;
                end_nxt   = IW'(hcnt_i);
                state_nxt = S_RD;
              end
            end
            ppsm_pkg::REQ_RELEASE: begin
              if (hcnt_i == '0) begin
                status_nxt = ppsm_pkg::ST_UNDEF;
                finish     = 1'b1;
              end else begin
                phase_nxt = PH_HFIND;
                op_nxt    = in_client_id;
                end_nxt   = IW'(hcnt_i);
                state_nxt = S_RD;
              end
            end
            ppsm_pkg::REQ_WAIT_IN: begin
              if (wcnt_i == WCNT_W'(WAITER_DEPTH)) begin
                status_nxt = ppsm_pkg::ST_INSUFF;
                finish     = 1'b1;
              end else begin
                idx_nxt                  = IW'(wcnt_i);
                app_wait_nxt             = 1'b1;
                wcnt_nxt[in_pool_select] = wcnt_i + 1'b1;
                state_nxt                = S_APPEND;
              end
            end
            default: begin
              if (wcnt_i == '0) begin
                status_nxt = ppsm_pkg::ST_UNDEF;
                finish     = 1'b1;
              end else begin
                phase_nxt = PH_WFIND;
                op_nxt    = in_client_id;
                end_nxt   = IW'(wcnt_i);
                state_nxt = S_RD;
              end
            end
          endcase
        end
      end

      S_RD: begin
        state_nxt = S_CMP;
      end

      S_CMP: begin
        case (phase_r)
          PH_PRIO: begin
            // first holder with the largest priority number above the best so far
            if (cmp_gt) begin
              op_nxt    = h_rd_prio;
              evid_nxt  = h_rd_id;
              found_nxt = 1'b1;
            end
            if (is_last) begin
              if (found_r || cmp_gt) begin
                // look up the first entry that carries the evicted id
                phase_nxt = PH_HFIND;
                op_nxt    = cmp_gt ? h_rd_id : evid_r;
                idx_nxt   = '0;
                state_nxt = S_RD;
              end else begin
                status_nxt = ppsm_pkg::ST_INSUFF;
                finish     = 1'b1;
              end
            end else begin
              idx_nxt   = IW'(idx_p1);
              state_nxt = S_RD;
            end
          end
          PH_HFIND: begin
            if (cmp_eq) begin
              if (is_last) begin
                hsh_done = 1'b1;
              end else begin
                phase_nxt = PH_HSHIFT;
                state_nxt = S_RD;
              end
            end else if (is_last) begin
              status_nxt = ppsm_pkg::ST_UNDEF;
              finish     = 1'b1;
            end else begin
              idx_nxt   = IW'(idx_p1);
              state_nxt = S_RD;
            end
          end
          PH_HSHIFT: begin
            h_we = 1'b1;
            if (is_last2) begin
              hsh_done = 1'b1;
            end else begin
              idx_nxt   = IW'(idx_p1);
              state_nxt = S_RD;
            end
          end
          PH_WHEAD: begin
            wkv_nxt  = 1'b1;
            wkid_nxt = w_rdata;
            if (is_last) begin
              wsh_done = 1'b1;
            end else begin
              phase_nxt = PH_WSHIFT;
              state_nxt = S_RD;
            end
          end
          PH_WFIND: begin
            if (cmp_eq) begin
              if (is_last) begin
                wsh_done = 1'b1;
              end else begin
                phase_nxt = PH_WSHIFT;
                state_nxt = S_RD;
              end
            end else if (is_last) begin
              status_nxt = ppsm_pkg::ST_NOTFOUND;
              finish     = 1'b1;
            end else begin
              idx_nxt   = IW'(idx_p1);
              state_nxt = S_RD;
            end
          end
          PH_WSHIFT: begin
            w_we = 1'b1;
            if (is_last2) begin
              wsh_done = 1'b1;
            end else begin
              idx_nxt   = IW'(idx_p1);
              state_nxt = S_RD;
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end

      S_APPEND: begin
        if (app_wait_r) begin
          w_we    = 1'b1;
          w_wdata = id_r;
        end else begin
          h_we    = 1'b1;
          h_wdata = {id_r, prio_r};
        end
        finish = 1'b1;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (hsh_done) begin
      if (req_r == ppsm_pkg::REQ_ACQUIRE) begin
        // requester takes the last slot, count unchanged
        evv_nxt      = 1'b1;
        idx_nxt      = end_r - 1'b1;
        app_wait_nxt = 1'b0;
        state_nxt    = S_APPEND;
      end else begin
        hcnt_nxt[pool_r] = hcnt_r[pool_r] - 1'b1;
        if (wcnt_r[pool_r] != '0) begin
          phase_nxt = PH_WHEAD;
          idx_nxt   = '0;
          end_nxt   = IW'(wcnt_r[pool_r]);
          state_nxt = S_RD;
        end else begin
          finish = 1'b1;
        end
      end
    end

    if (wsh_done) begin
      wcnt_nxt[pool_r] = wcnt_r[pool_r] - 1'b1;
      finish           = 1'b1;
    end

    if (finish) begin
      state_nxt = S_IDLE;
    end
    out_valid_nxt = finish;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_PRIO;
      out_valid_r <= 1'b0;
      hcnt_r[0]   <= '0;
      hcnt_r[1]   <= '0;
      wcnt_r[0]   <= '0;
      wcnt_r[1]   <= '0;
      lim_r[0]    <= ppsm_pkg::DEC_LIMIT_RST;
      lim_r[1]    <= ppsm_pkg::ENC_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      hcnt_r      <= hcnt_nxt;
      wcnt_r      <= wcnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          ppsm_pkg::CFG_DEC_LIMIT: lim_r[0] <= cfg_wdata;
          ppsm_pkg::CFG_ENC_LIMIT: lim_r[1] <= cfg_wdata;
          default: lim_r[0] <= lim_r[0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    pool_r     <= pool_nxt;
    id_r       <= id_nxt;
    prio_r     <= prio_nxt;
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    end_r      <= end_nxt;
    found_r    <= found_nxt;
    app_wait_r <= app_wait_nxt;
    status_r   <= status_nxt;
    evv_r      <= evv_nxt;
    evid_r     <= evid_nxt;
    wkv_r      <= wkv_nxt;
    wkid_r     <= wkid_nxt;
  end

  ppsm_ram #(
    .WIDTH (HE_W),
    .AW    (HIDX_W + 1)
  ) u_holder_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  ppsm_ram #(
    .WIDTH (ID_W),
    .AW    (WIDX_W + 1)
  ) u_waiter_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  assign busy              = state_r != S_IDLE;
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_evicted_valid = evv_r;
  assign out_evicted_id    = evid_r;
  assign out_wake_valid    = wkv_r;
  assign out_wake_id       = wkid_r;

  // a result only follows an accepted request or a request in progress
  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r != S_IDLE || start))
    else $error("result without a request");

  a_holder_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hcnt_r[0] <= HCNT_W'(HOLDER_DEPTH) && hcnt_r[1] <= HCNT_W'(HOLDER_DEPTH))
    else $error("holder count beyond depth");

  a_waiter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wcnt_r[0] <= WCNT_W'(WAITER_DEPTH) && wcnt_r[1] <= WCNT_W'(WAITER_DEPTH))
    else $error("waiter count beyond depth");

  // preemption only on a successful acquire, never together with a wake
  a_evict_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && evv_r |-> status_r == ppsm_pkg::ST_OK && !wkv_r
      && req_r == ppsm_pkg::REQ_ACQUIRE)
    else $error("eviction reported outside a successful acquire");

endmodule
